// File: hw/rtl/vtb_pkg.sv
// Shared types and constants for the virtual timer bank.
// Request and result payload structs, opcodes, controller/datapath links.
// No dependencies.
`default_nettype none

package vtb_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int PIN_COUNT       = 16;
    localparam int PIN_W           = 4;
    localparam int TIMEOUT_W       = 32;
    localparam int USED_OUT_W      = 5;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [TIMEOUT_W-1:0] timeout_count;
        logic [PIN_W-1:0]     pin_number;
        logic                 repeat_mode;
    } vtb_in_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0]  pin_levels;
        logic [PIN_COUNT-1:0]  ready_flags;
        logic [USED_OUT_W-1:0] slots_in_use;
        logic                  add_rejected;
    } vtb_out_t;

    typedef struct packed {
        logic latch;
        logic step;
        logic finish;
    } vtb_cmd_t;

    typedef struct packed {
        logic walk_needed;
        logic walk_last;
        logic out_free;
    } vtb_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/vtb_ctrl.sv
// Sequencer for the virtual timer bank.
// Steps a request through accept, slot walk, drain and finish.
// Depends on vtb_pkg.
`default_nettype none

module vtb_ctrl
    import vtb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire vtb_status_t status,
    output vtb_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = status.walk_needed ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vtb_datapath.sv
// Datapath for the virtual timer bank: slot memories, flags, pins, result register.
// Driven by vtb_ctrl through command and status structs.
// Depends on vtb_pkg.
`default_nettype none

module vtb_datapath
    import vtb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire vtb_in_t  in_data,
    input  wire vtb_cmd_t cmd,
    output vtb_status_t   status,
    output logic          out_valid,
    input  wire logic     out_ready,
    output vtb_out_t      out_data
);

    localparam int IDX_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
    localparam int SHOWN   = (TIMER_SLOTS < PIN_COUNT) ? TIMER_SLOTS : PIN_COUNT;
    localparam int USED_MAX = (1 << USED_OUT_W) - 1;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [PIN_W-1:0]     pin;
        logic                 rep;
    } slot_cfg_t;

    slot_cfg_t            cfg_mem [TIMER_SLOTS];
    logic [TIMEOUT_W-1:0] cnt_mem [TIMER_SLOTS];

    vtb_in_t              req_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     p_idx_reg;
    logic                 p_valid_reg;
    slot_cfg_t            cfg_rd_reg;
    logic [TIMEOUT_W-1:0] cnt_rd_reg;

    logic [TIMER_SLOTS-1:0] enabled_reg;
    logic [TIMER_SLOTS-1:0] enabled_next;
    logic [TIMER_SLOTS-1:0] ready_reg;
    logic [TIMER_SLOTS-1:0] ready_next;
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       used_next;
    logic [PIN_COUNT-1:0]   pin_reg;
    logic [PIN_COUNT-1:0]   pin_next;
    logic                   out_valid_reg;
    vtb_out_t               out_reg;
    vtb_out_t               out_next;

    logic                 full;
    logic                 add_ok;
    logic [IDX_W-1:0]     add_idx;
    logic                 hit;
    logic                 expired;
    logic                 cnt_we;
    logic [IDX_W-1:0]     cnt_waddr;
    logic [TIMEOUT_W-1:0] cnt_wdata;
    logic [PIN_COUNT-1:0] p_mask;
    logic [PIN_COUNT-1:0] shown_ready;

    assign full    = (used_reg >= CNT_W'(TIMER_SLOTS));
    assign add_idx = used_reg[IDX_W-1:0];
    assign add_ok  = cmd.finish && (req_reg.opcode == OP_ADD) && !full;
    assign hit     = p_valid_reg && (req_reg.opcode == OP_TICK) && enabled_reg[p_idx_reg];
    assign expired = (cnt_rd_reg >= cfg_rd_reg.timeout);
    assign p_mask  = PIN_COUNT'(1) << cfg_rd_reg.pin;

    assign status.walk_needed = ((in_data.opcode == OP_TICK) || (in_data.opcode == OP_DISABLE))
                                && (used_reg != '0);
    assign status.walk_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) >= used_reg);
    assign status.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = p_idx_reg;
        cnt_wdata = '0;
        if (add_ok)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = add_idx;
        end
        else if (hit && (!expired || cfg_rd_reg.rep))
        begin
            cnt_we    = 1'b1;
            cnt_wdata = expired ? '0 : cnt_rd_reg + TIMEOUT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_ok)
        begin
            cfg_mem[add_idx] <= '{timeout: req_reg.timeout_count,
                                  pin: req_reg.pin_number,
                                  rep: req_reg.repeat_mode};
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.step)
        begin
            cfg_rd_reg <= cfg_mem[idx_reg];
            cnt_rd_reg <= cnt_mem[idx_reg];
        end
    end

    always_comb
    begin
        enabled_next = enabled_reg;
        ready_next   = ready_reg;
        used_next    = used_reg;
        pin_next     = pin_reg;
        if (hit)
        begin
            if (expired)
            begin
                ready_next[p_idx_reg] = 1'b1;
                pin_next              = pin_reg ^ p_mask;
                if (!cfg_rd_reg.rep)
                begin
                    enabled_next[p_idx_reg] = 1'b0;
                end
            end
            else
            begin
                ready_next[p_idx_reg] = 1'b0;
            end
        end
        if (p_valid_reg && (req_reg.opcode == OP_DISABLE))
        begin
            pin_next = pin_reg & ~p_mask;
        end
        if (add_ok)
        begin
            enabled_next[add_idx] = 1'b1;
            ready_next[add_idx]   = 1'b0;
            used_next             = used_reg + CNT_W'(1);
        end
        if (cmd.finish && (req_reg.opcode == OP_DISABLE))
        begin
            enabled_next = '0;
            ready_next   = '0;
            used_next    = '0;
        end
    end

    always_comb
    begin
        shown_ready = '0;
        shown_ready[SHOWN-1:0] = ready_next[SHOWN-1:0];
    end

    always_comb
    begin
        out_next.pin_levels   = pin_next;
        out_next.ready_flags  = shown_ready;
        if (32'(used_next) > USED_MAX)
        begin
            out_next.slots_in_use = USED_OUT_W'(USED_MAX);
        end
        else
        begin
            out_next.slots_in_use = USED_OUT_W'(used_next);
        end
        out_next.add_rejected = (req_reg.opcode == OP_ADD) && full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= '0;
            ready_reg     <= '0;
            used_reg      <= '0;
            pin_reg       <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            enabled_reg <= enabled_next;
            ready_reg   <= ready_next;
            used_reg    <= used_next;
            pin_reg     <= pin_next;
            p_valid_reg <= cmd.step;
            if (cmd.latch)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= in_data;
        end
        if (cmd.step)
        begin
            p_idx_reg <= idx_reg;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/virtual_timer_bank.sv
// Top level of the virtual timer bank.
// Joins the sequencer vtb_ctrl and the datapath vtb_datapath; uses vtb_pkg.
//
// A bank of TIMER_SLOTS software timers stepped by a base tick request. An add
// request fills the next free slot (rejected and flagged when the bank is full),
// a tick request advances every enabled slot and toggles the pins of those that
// expire, and a disable request drives the pins of all filled slots low and
// empties the bank. Each request gives one result: pin levels, ready flags of
// slots 0..15, the fill count and the reject flag. An add, an unused opcode, or
// a tick or disable on an empty bank goes from acceptance straight to the finish
// state, which registers the result once the output register is free; a tick or
// disable on a bank with filled slots first walks the filled slots through the
// single read port of the slot memories, one slot per cycle, then passes the
// drain state before finishing. A new request is taken while the previous result
// still waits in the output register; its own result then stalls, and holds the
// input off, until that register is free.
`default_nettype none

module virtual_timer_bank
    import vtb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire vtb_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output vtb_out_t     out_data
);

    vtb_cmd_t    cmd;
    vtb_status_t status;

    vtb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vtb_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for virtual_timer_bank: a directed table of requests, then random bursts,
// every bank snapshot checked against a typed table value or an in-bench bank copy.
// Depends on vtb_pkg and virtual_timer_bank.

module tb;
    import vtb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SLOTS           = TIMER_SLOTS_DEF;
    localparam int RANDOM_REQUESTS = 1450;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        vtb_in_t  req;
        logic     typed;
        vtb_out_t want;
    } table_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    vtb_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    vtb_out_t out_data;

    logic [31:0] bank_timeout [SLOTS];
    logic [31:0] bank_count   [SLOTS];
    logic [3:0]  bank_pin     [SLOTS];
    logic        bank_repeat  [SLOTS];
    logic        bank_enabled [SLOTS];
    logic        bank_ready   [SLOTS];
    int          bank_used;
    logic [15:0] bank_pins;

    vtb_out_t   awaited_snapshots [$];
    table_row_t directed [$];
    int         mismatches;
    bit         hold_off_req;

    virtual_timer_bank uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic vtb_in_t make_request(input logic [1:0] op, input logic [31:0] tmo,
                                             input logic [3:0] pin, input logic rep);
        vtb_in_t r;
        r.opcode        = op;
        r.timeout_count = tmo;
        r.pin_number    = pin;
        r.repeat_mode   = rep;
        return r;
    endfunction

    function automatic vtb_out_t make_snapshot(input logic [15:0] pins, input logic [15:0] ready,
                                               input logic [4:0] used, input logic rej);
        vtb_out_t s;
        s.pin_levels   = pins;
        s.ready_flags  = ready;
        s.slots_in_use = used;
        s.add_rejected = rej;
        return s;
    endfunction

    function automatic vtb_out_t apply_timer_request(input vtb_in_t req);
        vtb_out_t res;
        int       idx;
        res = '0;
        case (req.opcode)
            OP_TICK:
            begin
                for (int i = 0; i < bank_used; i++)
                begin
                    if (bank_enabled[i])
                    begin
                        if (bank_count[i] >= bank_timeout[i])
                        begin
                            bank_ready[i] = 1'b1;
                            bank_pins[bank_pin[i]] = ~bank_pins[bank_pin[i]];
                            if (bank_repeat[i])
                                bank_count[i] = '0;
                            else
                                bank_enabled[i] = 1'b0;
                        end
                        else
                        begin
                            bank_count[i] = bank_count[i] + 32'd1;
                            bank_ready[i] = 1'b0;
                        end
                    end
                end
            end
            OP_ADD:
            begin
                if (bank_used >= SLOTS)
                    res.add_rejected = 1'b1;
                else
                begin
                    idx = bank_used;
                    bank_timeout[idx] = req.timeout_count;
                    bank_pin[idx]     = req.pin_number;
                    bank_repeat[idx]  = req.repeat_mode;
                    bank_count[idx]   = '0;
                    bank_ready[idx]   = 1'b0;
                    bank_enabled[idx] = 1'b1;
                    bank_used         = idx + 1;
                end
            end
            OP_DISABLE:
            begin
                for (int i = 0; i < bank_used; i++)
                    bank_pins[bank_pin[i]] = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    bank_enabled[i] = 1'b0;
                    bank_ready[i]   = 1'b0;
                end
                bank_used = 0;
            end
            default: ;
        endcase
        for (int i = 0; i < 16; i++)
            res.ready_flags[i] = bank_ready[i];
        res.pin_levels   = bank_pins;
        res.slots_in_use = 5'(bank_used);
        return res;
    endfunction

    function automatic vtb_in_t random_request();
        int          pick;
        int          span;
        logic [1:0]  op;
        logic [31:0] tmo;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 95)
            op = OP_ADD;
        else if (pick < 98)
            op = OP_DISABLE;
        else
            op = OP_UNUSED;
        if (span < 8)
            tmo = $urandom_range(0, 6);
        else if (span == 8)
            tmo = $urandom_range(0, 40);
        else
            tmo = $urandom;
        return make_request(op, tmo, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_request(input vtb_in_t req, input logic typed, input vtb_out_t want);
        vtb_out_t predicted;
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_timer_request(req);
        awaited_snapshots.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_snapshots.size() != 0);
    endtask

    initial
    begin
        vtb_out_t empty_bank;
        int       burst_left;
        int       gap;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        hold_off_req = 1'b0;
        mismatches   = 0;
        bank_used    = 0;
        bank_pins    = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            bank_enabled[i] = 1'b0;
            bank_ready[i]   = 1'b0;
        end

        empty_bank = make_snapshot(16'h0, 16'h0, 5'd0, 1'b0);
        directed.push_back('{make_request(OP_TICK, 32'd0, 4'd0, 1'b0), 1'b1, empty_bank});
        directed.push_back('{make_request(OP_DISABLE, 32'd0, 4'd0, 1'b0), 1'b1, empty_bank});
        directed.push_back('{make_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1), 1'b1,
                             empty_bank});
        directed.push_back('{make_request(OP_ADD, 32'd0, 4'd15, 1'b1), 1'b1,
                             make_snapshot(16'h0, 16'h0, 5'd1, 1'b0)});
        directed.push_back('{make_request(OP_TICK, 32'd0, 4'd0, 1'b0), 1'b0, empty_bank});
        directed.push_back('{make_request(OP_TICK, 32'd0, 4'd0, 1'b0), 1'b0, empty_bank});
        directed.push_back('{make_request(OP_ADD, 32'hFFFF_FFFF, 4'd0, 1'b0), 1'b0,
                             empty_bank});
        directed.push_back('{make_request(OP_ADD, 32'd1, 4'd15, 1'b0), 1'b0, empty_bank});
        for (int i = 0; i < 3; i++)
            directed.push_back('{make_request(OP_TICK, 32'd0, 4'd0, 1'b0), 1'b0, empty_bank});
        directed.push_back('{make_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1), 1'b0,
                             empty_bank});
        for (int i = 0; i < 13; i++)
            directed.push_back('{make_request(OP_ADD, 32'(i % 3), 4'(i + 1), 1'(i)), 1'b0,
                                 empty_bank});
        directed.push_back('{make_request(OP_ADD, 32'd5, 4'd14, 1'b1), 1'b0, empty_bank});
        directed.push_back('{make_request(OP_TICK, 32'd0, 4'd0, 1'b0), 1'b0, empty_bank});
        directed.push_back('{make_request(OP_DISABLE, 32'd0, 4'd0, 1'b0), 1'b1, empty_bank});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_request(directed[k].req, directed[k].typed, directed[k].want);
        wait_drained();

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 300)
                hold_off_req = 1'b1;
            if (n == 800)
                wait_drained();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            send_request(random_request(), 1'b0, empty_bank);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int cyc;
        cyc       = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                case ((cyc / 97) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (cyc % 5) == 0;
                    default: out_ready <= (cyc % 7) >= 3;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        vtb_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_snapshots.size() == 0)
                flag_mismatch("unexpected result", 32'(out_data.pin_levels), 32'h0);
            else
            begin
                want = awaited_snapshots.pop_front();
                if (out_data.pin_levels !== want.pin_levels)
                    flag_mismatch("pin_levels", 32'(out_data.pin_levels), 32'(want.pin_levels));
                if (out_data.ready_flags !== want.ready_flags)
                    flag_mismatch("ready_flags", 32'(out_data.ready_flags),
                                  32'(want.ready_flags));
                if (out_data.slots_in_use !== want.slots_in_use)
                    flag_mismatch("slots_in_use", 32'(out_data.slots_in_use),
                                  32'(want.slots_in_use));
                if (out_data.add_rejected !== want.add_rejected)
                    flag_mismatch("add_rejected", 32'(out_data.add_rejected),
                                  32'(want.add_rejected));
            end
        end
    end

endmodule
